[rtl/plpt_pkg.sv]
// Shared types and constants for the piecewise linear profile table.
// No dependencies.
package plpt_pkg;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int HGT_W = 18;
  localparam int ABS_W = 17;
  localparam int SLP_W = 42;
  localparam int OFS_W = 60;
  localparam int FRAC_SHIFT = 24;
  localparam int DIV_W = ABS_W + FRAC_SHIFT; // 41-bit dividend magnitude
  localparam logic signed [18:0] HEIGHT_MAX_Q = 19'sd160000;
  localparam logic [ABS_W-1:0] ABS_ONE_Q = 17'd65536;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_HEIGHT = 3'd1;
  localparam logic [2:0] ST_BAD_ABS = 3'd2;
  localparam logic [2:0] ST_NOT_ASC = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic append;     // write point, bump count
    logic div_start;  // start slope division
    logic div_step;   // one quotient bit
    logic seg_write;  // compute slope, stage 1
    logic seg_write2; // store slope and offset, stage 2
    logic scan_start; // start query scan
    logic scan_step;  // read one segment
    logic eval1;      // multiply
    logic eval2;      // add, saturate
    logic quick;      // result without a segment
    logic res_take;   // result register loaded
  } plpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic add_ok;
    logic need_seg;
    logic div_done;
    logic quick_hit;
    logic seg_hit;
    logic scan_end;
  } plpt_sts_t;
endpackage

[rtl/plpt_ctrl.sv]
// Controller state machine for the profile table.
// Depends on plpt_pkg.
module plpt_ctrl import plpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  plpt_sts_t sts,
  output plpt_cmd_t cmd,
  output logic      busy
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_SEG1  = 11'b00000001000,
    S_SEG2  = 11'b00000010000,
    S_QRY   = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_EV1   = 11'b00010000000,
    S_EV2   = 11'b00100000000,
    S_WAIT  = 11'b01000000000,
    S_RD    = 11'b10000000000
  } state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      // wait for the result register to free up
      S_WAIT: begin
        if (out_free) state_nxt = sts.is_query ? S_QRY : S_CHECK;
      end
      S_CHECK: begin
        if (sts.add_ok) begin
          cmd.append = 1'b1;
          if (sts.need_seg) begin
            cmd.div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            cmd.res_take = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.res_take = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_SEG1;
      end
      S_SEG1: begin
        cmd.seg_write = 1'b1;
        state_nxt = S_SEG2;
      end
      S_SEG2: begin
        cmd.seg_write2 = 1'b1;
        cmd.res_take = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        if (sts.quick_hit) begin
          cmd.quick = 1'b1;
          cmd.res_take = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = S_RD;
        end
      end
      // memory read latency slot
      S_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.seg_hit) state_nxt = S_EV1;
        else if (sts.scan_end) begin
          cmd.quick = 1'b1;
          cmd.res_take = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_EV1: begin
        cmd.eval1 = 1'b1;
        state_nxt = S_EV2;
      end
      S_EV2: begin
        cmd.eval2 = 1'b1;
        cmd.res_take = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[rtl/plpt_dp.sv]
// Datapath: point/segment memories, divider, scan and evaluation.
// Depends on plpt_pkg.
module plpt_dp import plpt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  plpt_cmd_t               cmd,
  input  logic                    in_opcode,
  input  logic signed [18:0]      in_height,
  input  logic [ABS_W-1:0]        in_absorption,
  output plpt_sts_t               sts,
  output logic [ABS_W-1:0]        res_abs,
  output logic [2:0]              res_status,
  output logic                    res_loaded
);
  // memories
  logic [HGT_W-1:0] hgt_mem [MAX_POINTS];
  logic signed [SLP_W-1:0] slp_mem [MAX_POINTS];
  logic signed [OFS_W-1:0] ofs_mem [MAX_POINTS];

  logic [CNT_W-1:0] count_r;
  logic op_r;
  logic signed [18:0] h_r;
  logic [ABS_W-1:0] a_r;
  // last point kept in registers
  logic [HGT_W-1:0] last_h_r;
  logic [ABS_W-1:0] last_a_r;

  // checks
  logic [2:0] chk_status;
  always_comb begin
    if (h_r < 0 || h_r > HEIGHT_MAX_Q) chk_status = ST_BAD_HEIGHT;
    else if (a_r > ABS_ONE_Q) chk_status = ST_BAD_ABS;
    else if (count_r != '0 && h_r[HGT_W-1:0] < last_h_r) chk_status = ST_NOT_ASC;
    else if (count_r >= CNT_W'(MAX_POINTS)) chk_status = ST_FULL;
    else chk_status = ST_OK;
  end

  // divider state
  logic [DIV_W-1:0] quo_r;
  logic [HGT_W-1:0] rem_r;
  logic [HGT_W-1:0] dz_r, z0_r;
  logic [ABS_W-1:0] a0_r;
  logic neg_r;
  logic [5:0] dcnt_r;
  logic signed [SLP_W-1:0] slope_r;
  logic [IDX_W-1:0] seg_idx_r;

  logic [ABS_W-1:0] da_mag;
  assign da_mag = (a_r >= last_a_r) ? a_r - last_a_r : last_a_r - a_r;
  logic [HGT_W:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};

  // scan state
  logic [IDX_W-1:0] k_r;
  logic [HGT_W-1:0] zk_q, zk1_q;
  logic signed [SLP_W-1:0] sk_q;
  logic signed [OFS_W-1:0] ok_q;
  logic signed [OFS_W-1:0] mul_r;
  logic signed [OFS_W-1:0] ofs_hold_r;
  logic signed [OFS_W-1:0] sum;
  logic [IDX_W-1:0] kp1;
  assign kp1 = k_r + 1'b1;

  always_ff @(posedge clk) begin
    zk_q <= hgt_mem[k_r];
    zk1_q <= hgt_mem[kp1];
    sk_q <= slp_mem[k_r];
    ok_q <= ofs_mem[k_r];
  end

  logic signed [19:0] h_ext, zk_ext, zk1_ext;
  assign h_ext = {h_r[18], h_r};
  assign zk_ext = {2'b00, zk_q};
  assign zk1_ext = {2'b00, zk1_q};

  // status toward controller
  assign sts.is_query = (op_r == OP_QUERY);
  assign sts.add_ok = (chk_status == ST_OK);
  assign sts.need_seg = (count_r != '0);
  assign sts.div_done = (dcnt_r == 6'(DIV_W - 1));
  assign sts.quick_hit = (count_r == '0) || (h_ext >= $signed({2'b00, last_h_r}))
                         || (count_r == CNT_W'(1));
  assign sts.seg_hit = (h_ext >= zk_ext) && (h_ext <= zk1_ext);
  assign sts.scan_end = ({1'b0, kp1} >= count_r - 1'b1);

  assign sum = mul_r + ofs_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      res_loaded <= 1'b0;
    end else begin
      if (cmd.append) begin
        count_r <= count_r + 1'b1;
        res_loaded <= 1'b1;
      end
    end
    if (cmd.load) begin
      op_r <= in_opcode;
      h_r <= in_height;
      a_r <= in_absorption;
    end
    if (cmd.append) begin
      hgt_mem[count_r[IDX_W-1:0]] <= h_r[HGT_W-1:0];
      last_h_r <= h_r[HGT_W-1:0];
      last_a_r <= a_r;
      z0_r <= last_h_r;
      a0_r <= last_a_r;
      seg_idx_r <= IDX_W'(count_r - 1'b1);
    end
    // restoring division, one bit a cycle
    if (cmd.div_start) begin
      quo_r <= {da_mag, {FRAC_SHIFT{1'b0}}};
      rem_r <= '0;
      dz_r <= h_r[HGT_W-1:0] - last_h_r;
      neg_r <= (a_r < last_a_r);
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (rem_sh >= {1'b0, dz_r}) begin
        rem_r <= HGT_W'(rem_sh - {1'b0, dz_r});
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[HGT_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.seg_write) begin
      if (dz_r == '0) slope_r <= '0;
      else if (neg_r) slope_r <= -$signed({1'b0, quo_r});
      else slope_r <= $signed({1'b0, quo_r});
    end
    if (cmd.seg_write2) begin
      slp_mem[seg_idx_r] <= slope_r;
      ofs_mem[seg_idx_r] <= $signed({{(OFS_W-ABS_W-FRAC_SHIFT){1'b0}}, a0_r,
                            {FRAC_SHIFT{1'b0}}}) - slope_r * $signed({1'b0, z0_r});
    end
    if (cmd.scan_start) k_r <= '0;
    else if (cmd.scan_step) k_r <= kp1;
    if (cmd.eval1) begin
      mul_r <= OFS_W'(sk_q) * OFS_W'(h_r);
      ofs_hold_r <= ok_q;
    end
    // result register; an add that stored a segment was accepted
    if (cmd.res_take) begin
      res_status <= ST_OK;
      res_abs <= '0;
      if (op_r == OP_ADD) begin
        if (!cmd.seg_write2) res_status <= chk_status;
      end else if (cmd.quick) begin
        if (count_r == '0) res_abs <= (h_r >= HEIGHT_MAX_Q) ? ABS_ONE_Q : '0;
        else if (h_ext >= $signed({2'b00, last_h_r})) res_abs <= last_a_r;
        else res_abs <= '0;
      end else if (cmd.eval2) begin
        if (sum < 0) res_abs <= '0;
        else if (sum[OFS_W-1:FRAC_SHIFT] > (OFS_W-FRAC_SHIFT)'(ABS_ONE_Q))
          res_abs <= ABS_ONE_Q;
        else res_abs <= sum[FRAC_SHIFT+ABS_W-1:FRAC_SHIFT];
      end
    end
  end
endmodule

[rtl/piecewise_linear_profile_table.sv]
// Top level of the piecewise linear profile table.
// Depends on plpt_pkg, plpt_ctrl, plpt_dp.
// Add: no division when rejected or first point; else the 41-bit slope divider runs.
// Query: direct result off-table, else segments scanned in turn and the hit evaluated.
// One item at a time; an accepted item waits until the previous result is taken.
// Synchronous active-low reset empties the table; memories are not cleared.
module piecewise_linear_profile_table import plpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // opcode[0], height_in[19:1], absorption_in[36:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata  // absorption_out[16:0], status[19:17], table_loaded[20]
);
  plpt_cmd_t cmd;
  plpt_sts_t sts;
  logic busy, in_fire, out_free, ov_r;
  logic [ABS_W-1:0] res_abs;
  logic [2:0] res_status;
  logic res_loaded;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;

  plpt_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .busy);
  plpt_dp u_dp (.clk, .rst_n, .cmd, .in_opcode(in_tdata[0]),
    .in_height($signed(in_tdata[19:1])), .in_absorption(in_tdata[36:20]),
    .sts, .res_abs, .res_status, .res_loaded);

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.res_take) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  assign out_tvalid = ov_r;
  assign out_tdata = {3'b000, res_loaded, res_status, res_abs};

  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_take |-> (!ov_r || out_tready)) else $error("result overwritten");
  a_busy_noaccept: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accept while busy");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_take |=> !busy) else $error("busy after result");
endmodule

[test/piecewise_linear_profile_table_tb.sv]
// Testbench for the piecewise linear profile table: directed and random add/query
// transactions checked against an in-bench interpolation predictor.
// Depends on plpt_pkg and the piecewise_linear_profile_table RTL.
module piecewise_linear_profile_table_tb;
  import plpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0] absorption;
    logic [2:0]  status;
    logic        loaded;
  } profile_result_t;

  // Scoreboard: holds its own copy of the table and the queue of expected results
  class profile_scoreboard;
    logic [17:0] hgt [MAX_POINTS];
    logic [16:0] absv [MAX_POINTS];
    logic signed [63:0] slope [MAX_POINTS];
    logic signed [63:0] offset [MAX_POINTS];
    int count;
    int errors;
    profile_result_t pending [$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    function logic [16:0] interpolate(logic signed [63:0] h);
      logic signed [63:0] s;
      logic signed [63:0] r;
      if (count == 0) return (h >= 160000) ? ABS_ONE_Q : 17'd0;
      if (h >= $signed({46'd0, hgt[count-1]})) return absv[count-1];
      for (int k = 0; k + 1 < count; k++) begin
        if (h >= $signed({46'd0, hgt[k]}) && h <= $signed({46'd0, hgt[k+1]})) begin
          s = h * slope[k] + offset[k];
          if (s < 0) return 17'd0;
          r = s >>> FRAC_SHIFT;
          return (r > 65536) ? ABS_ONE_Q : r[16:0];
        end
      end
      return 17'd0;
    endfunction

    function void note_item(logic op, logic signed [18:0] h, logic [16:0] a);
      profile_result_t res;
      logic signed [63:0] dz;
      logic signed [63:0] da;
      logic [63:0] q;
      int k;
      res = '0;
      if (op == OP_QUERY) res.absorption = interpolate(h);
      else if (h < 0 || h > HEIGHT_MAX_Q) res.status = ST_BAD_HEIGHT;
      else if (a > ABS_ONE_Q) res.status = ST_BAD_ABS;
      else if (count > 0 && h < $signed({1'b0, hgt[count-1]})) res.status = ST_NOT_ASC;
      else if (count >= MAX_POINTS) res.status = ST_FULL;
      else begin
        hgt[count] = h[17:0];
        absv[count] = a;
        count++;
        if (count > 1) begin
          k = count - 2;
          dz = hgt[k+1] - hgt[k];
          da = $signed({47'd0, absv[k+1]}) - $signed({47'd0, absv[k]});
          slope[k] = 0;
          if (dz > 0) begin
            q = ((da < 0 ? -da : da) << FRAC_SHIFT) / dz;
            slope[k] = (da < 0) ? -$signed(q) : $signed(q);
          end
          offset[k] = ($signed({47'd0, absv[k]}) <<< FRAC_SHIFT) - slope[k] * hgt[k];
        end
      end
      res.loaded = (count > 0);
      pending.insert(pending.size(), res);
    endfunction

    task check_result(logic [23:0] data);
      profile_result_t got;
      profile_result_t want;
      got = {data[16:0], data[19:17], data[20]};
      if (pending.size() == 0) begin
        report("result with nothing expected", data);
        return;
      end
      want = pending.pop_front();
      if (got.absorption !== want.absorption) report("absorption_out mismatch", data);
      if (got.status !== want.status) report("status mismatch", data);
      if (got.loaded !== want.loaded) report("table_loaded mismatch", data);
      if (data[23:21] !== 3'd0) report("padding bits not zero", data);
    endtask

    task report(string what, logic [23:0] data);
      errors++;
      $display("mismatch: %s (out_tdata=%h)", what, data);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;   // opcode[0], height_in[19:1], absorption_in[36:20]
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;  // absorption_out[16:0], status[19:17], table_loaded[20]

  profile_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;
  int last_h;

  piecewise_linear_profile_table i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("piecewise_linear_profile_table_tb: FAIL");
      $finish;
    end
  end

  // Result sink: sample at rising edge, randomize tready at falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One add/query transaction, with optional idle gap beforehand
  task automatic send_item(logic op, logic signed [18:0] h, logic [16:0] a);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {3'd0, a, h, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, h, a);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_query();
    int r;
    logic signed [18:0] h;
    r = $urandom_range(9);
    if (r == 0) h = 19'($urandom);
    else if (r == 1 && sb.count > 0) h = {1'b0, sb.hgt[$urandom_range(sb.count-1)]};
    else h = 19'($urandom_range(165000));
    send_item(OP_QUERY, h, 17'($urandom));
  endtask

  // Builds a table of n points, with some equal heights, and queries it
  task automatic random_table(int n, int queries);
    int h;
    int a;
    for (int i = 0; i < n; i++) begin
      h = last_h + (($urandom_range(4) == 0) ? 0 : $urandom_range(1, 160000 / n));
      if (h > 160000) h = 160000;
      a = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 65536 : 0) : $urandom_range(65536);
      send_item(OP_ADD, 19'(h), 17'(a));
      last_h = h;
      if ($urandom_range(7) == 0) send_item(OP_ADD, 19'($urandom), 17'($urandom));
    end
    for (int i = 0; i < queries; i++) random_query();
  endtask

  initial begin
    int phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{76, 0}, '{0, 76}, '{21, 21}};
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, range checks, equal heights, extremes
    send_item(OP_QUERY, 19'sd160000, 17'd0);
    send_item(OP_QUERY, 19'sd159999, 17'h1ffff);
    send_item(OP_QUERY, -19'sd1, 17'd0);
    send_item(OP_ADD, -19'sd1, 17'd0);
    send_item(OP_ADD, 19'sd160001, 17'd0);
    send_item(OP_ADD, 19'sd262143, 17'd5);
    send_item(OP_ADD, -19'sd262144, 17'd5);
    send_item(OP_ADD, 19'sd100, 17'd65537);
    send_item(OP_ADD, 19'sd100, 17'h1ffff);
    send_item(OP_ADD, 19'sd0, 17'd0);
    send_item(OP_ADD, 19'sd0, 17'd65536);
    send_item(OP_ADD, 19'sd1600, 17'd1000);
    send_item(OP_ADD, 19'sd1000, 17'd1000);
    send_item(OP_ADD, 19'sd1600, 17'd30000);
    send_item(OP_ADD, 19'sd160000, 17'd65536);
    send_item(OP_QUERY, 19'sd0, 17'd0);
    send_item(OP_QUERY, 19'sd800, 17'd0);
    send_item(OP_QUERY, 19'sd1600, 17'd0);
    send_item(OP_QUERY, 19'sd50000, 17'd0);
    send_item(OP_QUERY, 19'sd160000, 17'd0);
    send_item(OP_QUERY, 19'sd262143, 17'd0);
    send_item(OP_QUERY, -19'sd262144, 17'd0);
    drain();

    // Random phases: build tables (one fills to full), then query them
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int t = 0; t < 4; t++) begin
        drain();
        @(negedge clk);
        if (sb.count >= MAX_POINTS - 2 || t == 0) begin
          // table can only restart from reset, so keep filling: full-table case
          for (int i = 0; i < 4; i++)
            send_item(OP_ADD, 19'sd160000, 17'($urandom_range(65536)));
        end
        last_h = (sb.count > 0) ? int'(sb.hgt[sb.count-1]) : 0;
        random_table((p == 0 && t == 0) ? 20 : $urandom_range(1, 12), 90);
      end
    end
    drain();
    if (sb.errors == 0) $display("piecewise_linear_profile_table_tb: PASS");
    else $display("piecewise_linear_profile_table_tb: FAIL");
    $finish;
  end
endmodule
